FILE: hw/rtl/gpps_pkg.sv
package gpps_pkg;

    typedef enum logic [1:0] {
        MODE_TAG  = 2'd0,
        MODE_DATA = 2'd1,
        MODE_SKIP = 2'd2
    } t_mode;

    localparam logic [3:0] DESC_PRIM  = 4'h0;
    localparam logic [3:0] DESC_RGBAQ = 4'h1;
    localparam logic [3:0] DESC_XYZ2  = 4'h5;
    localparam logic [3:0] DESC_AD    = 4'hE;

    localparam logic [7:0] ADDR_PRIM   = 8'h00;
    localparam logic [7:0] ADDR_RGBAQ  = 8'h01;
    localparam logic [7:0] ADDR_XYZ2   = 8'h05;
    localparam logic [7:0] ADDR_FRAME  = 8'h4C;
    localparam logic [7:0] ADDR_OFFSET = 8'h18;

    localparam logic [2:0]  SPRITE_TYPE   = 3'd6;
    localparam logic [11:0] DEFAULT_WIDTH = 12'd640;
    localparam int          QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_PRIM   = 3'd1,
        OP_COLOR  = 3'd2,
        OP_VERTEX = 3'd3,
        OP_FRAME  = 3'd4,
        OP_OFFSET = 3'd5
    } t_op;

    // classified command from the front end
    typedef struct packed {
        t_op         op;
        logic        count_data;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_cmd;

    typedef struct packed {
        logic        fill_valid;
        logic [11:0] rect_x_start;
        logic [11:0] rect_y_start;
        logic [12:0] rect_x_end;
        logic [12:0] rect_y_end;
        logic [31:0] fill_color;
        logic [8:0]  frame_base;
        logic [11:0] frame_width;
        logic [31:0] sprite_count;
        logic [31:0] unsupported_count;
        logic [31:0] data_qword_count;
    } t_result;

endpackage

FILE: hw/rtl/gpps_if.sv
interface gpps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [15:0] qwords_after;
    modport source (output valid, word0, word1, word2, word3, qwords_after, input ready);
    modport sink (input valid, word0, word1, word2, word3, qwords_after, output ready);
endinterface

interface gpps_out_if;
    logic              valid;
    logic              ready;
    gpps_pkg::t_result result;
    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

FILE: hw/rtl/gpps_front.sv
module gpps_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gpps_in_if.sink             i_in,
    output logic                o_cmd_valid,
    output gpps_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_ready
);
    gpps_pkg::t_mode r_mode, n_mode;
    logic [14:0] r_loops, n_loops;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_nreg, n_nreg;
    logic [63:0] r_desc, n_desc;
    logic [14:0] r_skip, n_skip;

    logic        w_acc;
    logic [14:0] w_nloop;
    logic [1:0]  w_flg;
    logic [3:0]  w_nreg;
    logic [3:0]  w_dsc;
    logic [3:0]  w_idx_inc;

    assign i_in.ready  = i_cmd_ready;
    assign o_cmd_valid = i_in.valid;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_nloop     = i_in.word0[14:0];
    assign w_flg       = i_in.word1[27:26];
    assign w_nreg      = i_in.word1[31:28];
    assign w_dsc       = r_desc[{r_idx, 2'b00} +: 4];
    assign w_idx_inc   = r_idx + 4'd1;

    always_comb begin
        n_mode  = r_mode;
        n_loops = r_loops;
        n_idx   = r_idx;
        n_nreg  = r_nreg;
        n_desc  = r_desc;
        n_skip  = r_skip;
        case (r_mode)
            gpps_pkg::MODE_DATA: begin
                if (w_idx_inc >= r_nreg) begin
                    n_idx   = 4'd0;
                    n_loops = r_loops - 15'd1;
                    if (n_loops == 15'd0) n_mode = gpps_pkg::MODE_TAG;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            gpps_pkg::MODE_SKIP: begin
                n_skip = r_skip - 15'd1;
                if (n_skip == 15'd0) n_mode = gpps_pkg::MODE_TAG;
            end
            default: begin
                if (w_flg != 2'd0 || w_nreg == 4'd0) begin
                    if (w_nloop != 15'd0 && {1'b0, w_nloop} <= i_in.qwords_after) begin
                        n_skip = w_nloop;
                        n_mode = gpps_pkg::MODE_SKIP;
                    end
                end else if (w_nloop != 15'd0) begin
                    n_loops = w_nloop;
                    n_nreg  = w_nreg;
                    n_idx   = 4'd0;
                    n_desc  = {i_in.word3, i_in.word2};
                    n_mode  = gpps_pkg::MODE_DATA;
                end
            end
        endcase
        if (i_in.qwords_after == 16'd0) n_mode = gpps_pkg::MODE_TAG;
    end

    always_comb begin
        o_cmd.op         = gpps_pkg::OP_NONE;
        o_cmd.count_data = 1'b0;
        o_cmd.lo         = i_in.word0;
        o_cmd.hi         = i_in.word1;
        case (r_mode)
            gpps_pkg::MODE_DATA: begin
                o_cmd.count_data = 1'b1;
                case (w_dsc)
                    gpps_pkg::DESC_PRIM:  o_cmd.op = gpps_pkg::OP_PRIM;
                    gpps_pkg::DESC_RGBAQ: begin
                        o_cmd.op = gpps_pkg::OP_COLOR;
                        o_cmd.lo = {8'hFF, i_in.word2[7:0], i_in.word1[7:0], i_in.word0[7:0]};
                    end
                    gpps_pkg::DESC_XYZ2:  o_cmd.op = gpps_pkg::OP_VERTEX;
                    gpps_pkg::DESC_AD: begin
                        case (i_in.word2[7:0])
                            gpps_pkg::ADDR_PRIM:   o_cmd.op = gpps_pkg::OP_PRIM;
                            gpps_pkg::ADDR_RGBAQ:  o_cmd.op = gpps_pkg::OP_COLOR;
                            gpps_pkg::ADDR_XYZ2:   o_cmd.op = gpps_pkg::OP_VERTEX;
                            gpps_pkg::ADDR_FRAME:  o_cmd.op = gpps_pkg::OP_FRAME;
                            gpps_pkg::ADDR_OFFSET: o_cmd.op = gpps_pkg::OP_OFFSET;
                            default:               o_cmd.op = gpps_pkg::OP_NONE;
                        endcase
                    end
                    default: o_cmd.op = gpps_pkg::OP_NONE;
                endcase
            end
            gpps_pkg::MODE_SKIP: o_cmd.op = gpps_pkg::OP_NONE;
            default: begin
                // PRE on a tag: primitive sits in word1 bits 15-17
                if (i_in.word1[14]) begin
                    o_cmd.op = gpps_pkg::OP_PRIM;
                    o_cmd.lo = {29'd0, i_in.word1[17:15]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= gpps_pkg::MODE_TAG;
            r_loops <= '0;
            r_idx   <= '0;
            r_nreg  <= '0;
            r_desc  <= '0;
            r_skip  <= '0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_loops <= n_loops;
            r_idx   <= n_idx;
            r_nreg  <= n_nreg;
            r_desc  <= n_desc;
            r_skip  <= n_skip;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.qwords_after == 16'd0) |=> r_mode == gpps_pkg::MODE_TAG)
        else $error("mode not back to tag at transfer end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == gpps_pkg::MODE_DATA |-> r_nreg != 4'd0 && r_loops != 15'd0)
        else $error("data mode with empty loop");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == gpps_pkg::MODE_SKIP |-> r_skip != 15'd0)
        else $error("skip mode with zero count");
endmodule

FILE: hw/rtl/gpps_queue.sv
module gpps_queue #(
    parameter int DEPTH = gpps_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gpps_pkg::t_cmd i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output gpps_pkg::t_cmd o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    gpps_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue overflow");
endmodule

FILE: hw/rtl/gpps_back.sv
module gpps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  gpps_pkg::t_cmd i_cmd,
    gpps_out_if.source     o_out
);
    logic [2:0]  r_prim;
    logic [31:0] r_color;
    logic [12:0] r_fx, r_fy;
    logic        r_have;
    logic [15:0] r_offx, r_offy;
    logic [8:0]  r_fbase;
    logic [11:0] r_fwidth;
    logic [31:0] r_spr, r_uns, r_dq;
    logic        r_ovalid;
    gpps_pkg::t_result r_res, n_res;

    logic        w_go;
    logic [16:0] w_bx, w_by;
    logic [12:0] w_vx, w_vy;
    logic signed [12:0] w_x0, w_x1, w_y0, w_y1;
    logic [11:0] w_width;
    logic        w_sprite;

    assign o_cmd_ready = !r_ovalid || o_out.ready;
    assign w_go        = i_cmd_valid && o_cmd_ready;
    assign o_out.valid = r_ovalid;
    assign o_out.result = r_res;

    // floor((raw - off) / 16) via biased subtraction
    assign w_bx = {1'b1, i_cmd.lo[15:0]} - {1'b0, r_offx};
    assign w_by = {1'b1, i_cmd.hi[15:0]} - {1'b0, r_offy};
    assign w_vx = w_bx[16:4] - 13'd4096;
    assign w_vy = w_by[16:4] - 13'd4096;

    always_comb begin
        if ($signed(w_vx) < $signed(r_fx)) begin
            w_x0 = w_vx; w_x1 = r_fx;
        end else begin
            w_x0 = r_fx; w_x1 = w_vx;
        end
        if ($signed(w_vy) < $signed(r_fy)) begin
            w_y0 = w_vy; w_y1 = r_fy;
        end else begin
            w_y0 = r_fy; w_y1 = w_vy;
        end
    end

    assign w_width  = {i_cmd.lo[14:9], 6'd0};
    assign w_sprite = i_cmd.op == gpps_pkg::OP_VERTEX && r_have
                      && r_prim == gpps_pkg::SPRITE_TYPE;

    always_comb begin
        n_res = '0;
        n_res.sprite_count      = r_spr + {31'd0, w_sprite};
        n_res.unsupported_count = r_uns + {31'd0, i_cmd.op == gpps_pkg::OP_VERTEX
                                           && r_have && !w_sprite};
        n_res.data_qword_count  = r_dq + {31'd0, i_cmd.count_data};
        if (w_sprite) begin
            n_res.fill_valid   = 1'b1;
            n_res.rect_x_start = w_x0[12] ? 12'd0 : w_x0[11:0];
            n_res.rect_y_start = w_y0[12] ? 12'd0 : w_y0[11:0];
            n_res.rect_x_end   = w_x1;
            n_res.rect_y_end   = w_y1;
            n_res.fill_color   = r_color;
            n_res.frame_base   = r_fbase;
            n_res.frame_width  = r_fwidth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim   <= '0;
            r_color  <= '0;
            r_fx     <= '0;
            r_fy     <= '0;
            r_have   <= 1'b0;
            r_offx   <= '0;
            r_offy   <= '0;
            r_fbase  <= '0;
            r_fwidth <= gpps_pkg::DEFAULT_WIDTH;
            r_spr    <= '0;
            r_uns    <= '0;
            r_dq     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_go) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            if (w_go) begin
                if (i_cmd.count_data) r_dq <= r_dq + 32'd1;
                case (i_cmd.op)
                    gpps_pkg::OP_PRIM:  r_prim  <= i_cmd.lo[2:0];
                    gpps_pkg::OP_COLOR: r_color <= i_cmd.lo;
                    gpps_pkg::OP_VERTEX: begin
                        if (!r_have) begin
                            r_fx   <= w_vx;
                            r_fy   <= w_vy;
                            r_have <= 1'b1;
                        end else begin
                            r_have <= 1'b0;
                            if (w_sprite) r_spr <= r_spr + 32'd1;
                            else          r_uns <= r_uns + 32'd1;
                        end
                    end
                    gpps_pkg::OP_FRAME: begin
                        r_fbase  <= i_cmd.lo[8:0];
                        r_fwidth <= (w_width == 12'd0) ? gpps_pkg::DEFAULT_WIDTH : w_width;
                    end
                    gpps_pkg::OP_OFFSET: begin
                        r_offx <= i_cmd.lo[15:0];
                        r_offy <= i_cmd.hi[15:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) r_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid)
        else $error("result dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_sprite) |=> r_spr == $past(r_spr) + 32'd1 && !r_have)
        else $error("sprite count not advanced");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_res.fill_valid) |->
        ($signed(r_res.rect_x_end) >= $signed({1'b0, r_res.rect_x_start})
         || r_res.rect_x_end[12]))
        else $error("unordered rectangle");
endmodule

FILE: hw/rtl/graphics_packet_parser_sprite.sv
// A quadword's result appears in the cycle after its command leaves the queue;
// an accepted quadword passes the command queue, then the output register.
// Throughput: one quadword per cycle; the back end's output register and the
// two-entry command queue let either side stall on its own.
// Reset (i_rst_n low, synchronous) clears parser state, counters and the queue;
// frame width returns to 640.
module graphics_packet_parser_sprite #(
    parameter int QUEUE_DEPTH = gpps_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpps_in_if.sink   i_in,
    gpps_out_if.source o_out
);
    logic           w_fv, w_fr, w_qv, w_qr;
    gpps_pkg::t_cmd w_fc, w_qc;

    gpps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_cmd_valid(w_fv), .o_cmd(w_fc), .i_cmd_ready(w_fr)
    );

    gpps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fc),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qc)
    );

    gpps_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_qv), .o_cmd_ready(w_qr), .i_cmd(w_qc), .o_out(o_out)
    );
endmodule
